// ----- rtl/sha1_byte_stream_hasher_core_defines.svh -----
// Assertion macros for the SHA-1 hasher checker.
`ifndef SHA1_BYTE_STREAM_HASHER_CORE_DEFINES_SVH
`define SHA1_BYTE_STREAM_HASHER_CORE_DEFINES_SVH

// Clocked check, switched off while reset is held.
`define SHA1BSH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds through reset.
`define SHA1BSH_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/sha1bsh_pkg.sv -----
// Types and constants of the SHA-1 byte stream hasher.
`timescale 1ns / 1ps

package sha1bsh_pkg;

  localparam int unsigned SHA1_WORDS  = 5;
  localparam int unsigned SHA1_ROUNDS = 80;
  localparam int unsigned COUNT_W     = 61;

  // Initial chaining value, index 0 is the first word
  localparam logic [SHA1_WORDS-1:0][31:0] SHA1_IV = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  // Round constants, one per group of twenty rounds
  localparam logic [31:0] SHA1_K0 = 32'h5A827999;
  localparam logic [31:0] SHA1_K1 = 32'h6ED9EBA1;
  localparam logic [31:0] SHA1_K2 = 32'h8F1BBCDC;
  localparam logic [31:0] SHA1_K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       is_final;
  } sha1bsh_in_t;

  // Output word
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha1bsh_out_t;

  // Working variables of the compression
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } sha1bsh_work_t;

endpackage

// ----- rtl/sha1_byte_stream_hasher_core.sv -----
// Top level of the SHA-1 byte stream hasher.
`timescale 1ns / 1ps

// SHA-1 hasher taking one message byte per input word. The byte that completes
// a 64-byte block holds the input off for 80 rounds through the single shared
// round unit and then a fold of the result into the chaining value. A final
// word pads the message one byte a cycle, paused while a block is compressed,
// running one or two further compressions, and then offers the five digest
// words, word 0 first, one per cycle as the output side takes them. The input
// is stalled from the final word until the last digest word has been taken;
// the hasher is then back at the initial chaining value for the next message.
// On a long message the pace is set by the loop that runs one round per cycle.

module sha1_byte_stream_hasher_core import sha1bsh_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  sha1bsh_in_t  in_data_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output sha1bsh_out_t out_data_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PAD   = 3'd1;
  localparam logic [2:0] ST_ROUND = 3'd2;
  localparam logic [2:0] ST_FOLD  = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  localparam logic [6:0] LAST_ROUND = 7'(SHA1_ROUNDS - 1);
  localparam logic [2:0] LAST_IDX   = 3'(SHA1_WORDS - 1);

  logic [2:0]         state_q, state_d;
  logic [2:0]         ret_q, ret_d;
  logic [5:0]         fill_q, fill_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [6:0]         round_q, round_d;
  logic [2:0]         widx_q, widx_d;
  logic               pad_first_q, pad_first_d;
  logic               len_ok_q, len_ok_d;
  logic [31:0]        chain_q [SHA1_WORDS];
  logic [15:0][31:0]  win_q;
  sha1bsh_work_t      work_q;
  sha1bsh_work_t      work_next;

  logic               in_acc;
  logic               out_acc;
  logic               push_en;
  logic [7:0]         push_byte;
  logic               wrap;
  logic               start_comp;
  logic [63:0]        bit_len;
  logic [7:0][7:0]    len_bytes;
  logic [7:0]         pad_byte;
  logic [31:0]        w_mix;
  logic [31:0]        w_new;
  logic [511:0]       win_flat;
  sha1bsh_work_t      chain_work;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Handshake: input open only when idle, digest on offer in the emit state
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT);

  always_comb begin
    out_data_o.digest_word = chain_q[widx_q];
    out_data_o.word_index  = widx_q;
    out_data_o.last_word   = (widx_q == LAST_IDX);
  end

  // Padding byte: 0x80 first, then zeros, then the big-endian bit length
  assign bit_len   = {count_q, 3'b000};
  assign len_bytes = bit_len;
  always_comb begin
    if (pad_first_q) begin
      pad_byte = PAD_BYTE;
    end else if (len_ok_q && fill_q >= 6'd56) begin
      pad_byte = len_bytes[~fill_q[2:0]];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // Byte into the block buffer
  assign push_en   = (state_q == ST_IDLE && in_acc && in_data_i.byte_present) ||
                     (state_q == ST_PAD);
  assign push_byte = (state_q == ST_PAD) ? pad_byte : in_data_i.data_byte;
  assign wrap      = push_en && (fill_q == 6'd63);

  // Schedule expansion; the oldest word sits at the top of the window
  assign w_mix = win_q[2] ^ win_q[7] ^ win_q[13] ^ win_q[15];
  assign w_new = {w_mix[30:0], w_mix[31]};

  assign chain_work = '{a: chain_q[0], b: chain_q[1], c: chain_q[2],
                        d: chain_q[3], e: chain_q[4]};

  sha1bsh_round u_round (
    .work_i  (work_q),
    .w_i     (win_q[15]),
    .round_i (round_q),
    .work_o  (work_next)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    fill_d      = fill_q;
    count_d     = count_q;
    round_d     = round_q;
    widx_d      = widx_q;
    pad_first_d = pad_first_q;
    len_ok_d    = len_ok_q;
    start_comp  = 1'b0;

    if (push_en) begin
      fill_d = fill_q + 6'd1;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data_i.byte_present) begin
            count_d = count_q + COUNT_W'(1);
          end
          if (in_data_i.is_final) begin
            pad_first_d = 1'b1;
            len_ok_d    = 1'b0;
          end
          if (wrap) begin
            start_comp = 1'b1;
            state_d    = ST_ROUND;
            ret_d      = in_data_i.is_final ? ST_PAD : ST_IDLE;
          end else if (in_data_i.is_final) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        pad_first_d = 1'b0;
        if (pad_first_q && fill_q < 6'd56) begin
          len_ok_d = 1'b1;
        end
        if (wrap) begin
          start_comp = 1'b1;
          state_d    = ST_ROUND;
          len_ok_d   = 1'b1;
          ret_d      = (len_ok_q && !pad_first_q) ? ST_EMIT : ST_PAD;
        end
      end
      ST_ROUND: begin
        round_d = round_q + 7'd1;
        if (round_q == LAST_ROUND) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        state_d = ret_q;
        widx_d  = 3'd0;
      end
      ST_EMIT: begin
        if (out_acc) begin
          widx_d = widx_q + 3'd1;
          if (widx_q == LAST_IDX) begin
            state_d = ST_IDLE;
            count_d = '0;
            widx_d  = 3'd0;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (start_comp) begin
      round_d = 7'd0;
    end
  end

  // Control and chaining registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= ST_IDLE;
      fill_q      <= '0;
      count_q     <= '0;
      round_q     <= '0;
      widx_q      <= '0;
      pad_first_q <= 1'b0;
      len_ok_q    <= 1'b0;
      for (int i = 0; i < SHA1_WORDS; i++) begin
        chain_q[i] <= SHA1_IV[i];
      end
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      fill_q      <= fill_d;
      count_q     <= count_d;
      round_q     <= round_d;
      widx_q      <= widx_d;
      pad_first_q <= pad_first_d;
      len_ok_q    <= len_ok_d;
      if (state_q == ST_FOLD) begin
        chain_q[0] <= chain_q[0] + work_q.a;
        chain_q[1] <= chain_q[1] + work_q.b;
        chain_q[2] <= chain_q[2] + work_q.c;
        chain_q[3] <= chain_q[3] + work_q.d;
        chain_q[4] <= chain_q[4] + work_q.e;
      end else if (state_q == ST_EMIT && out_acc && widx_q == LAST_IDX) begin
        for (int i = 0; i < SHA1_WORDS; i++) begin
          chain_q[i] <= SHA1_IV[i];
        end
      end
    end
  end

  // Block buffer / schedule window and working variables
  assign win_flat = win_q;
  always_ff @(posedge clk_i) begin
    if (push_en) begin
      win_q <= {win_flat[503:0], push_byte};
    end else if (state_q == ST_ROUND) begin
      win_q <= {win_q[14:0], w_new};
    end
    if (start_comp) begin
      work_q <= chain_work;
    end else if (state_q == ST_ROUND) begin
      work_q <= work_next;
    end
  end

endmodule

// ----- rtl/sha1bsh_round.sv -----
// One SHA-1 compression round, shared by all 80 rounds of a block.
`timescale 1ns / 1ps

module sha1bsh_round import sha1bsh_pkg::*; (
  input  sha1bsh_work_t work_i,
  input  logic [31:0]   w_i,
  input  logic [6:0]    round_i,
  output sha1bsh_work_t work_o
);

  logic [31:0] f;
  logic [31:0] k;

  // Round function and constant by group of twenty
  always_comb begin
    if (round_i < 7'd20) begin
      f = (work_i.b & work_i.c) | (~work_i.b & work_i.d);
      k = SHA1_K0;
    end else if (round_i < 7'd40) begin
      f = work_i.b ^ work_i.c ^ work_i.d;
      k = SHA1_K1;
    end else if (round_i < 7'd60) begin
      f = (work_i.b & work_i.c) | (work_i.b & work_i.d) | (work_i.c & work_i.d);
      k = SHA1_K2;
    end else begin
      f = work_i.b ^ work_i.c ^ work_i.d;
      k = SHA1_K3;
    end
  end

  // Rotate the working variables
  always_comb begin
    work_o.a = {work_i.a[26:0], work_i.a[31:27]} + f + work_i.e + k + w_i;
    work_o.b = work_i.a;
    work_o.c = {work_i.b[1:0], work_i.b[31:2]};
    work_o.d = work_i.c;
    work_o.e = work_i.d;
  end

endmodule

// ----- rtl/sha1bsh_checker.sv -----
// Port-level checker for the SHA-1 byte stream hasher, bound to the top level.
`timescale 1ns / 1ps
`include "sha1_byte_stream_hasher_core_defines.svh"

module sha1bsh_checker import sha1bsh_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         in_valid_i,
  input logic         in_stall_o,
  input sha1bsh_in_t  in_data_i,
  input logic         out_valid_o,
  input logic         out_stall_i,
  input sha1bsh_out_t out_data_o
);

  // No new message word is taken while a digest is on offer
  `SHA1BSH_ASSERT(a_stall_while_emit, out_valid_o |-> in_stall_o, "input open during digest output")

  // A word that does not end a message gives no digest in the next cycle
  `SHA1BSH_ASSERT(a_no_early_digest, (in_valid_i && !in_stall_o && !in_data_i.is_final) |=> !out_valid_o, "digest without final word")

  // Digest words come in order
  `SHA1BSH_ASSERT(a_index_steps, (out_valid_o && !out_stall_i && !out_data_o.last_word) |=> (out_valid_o && out_data_o.word_index == $past(out_data_o.word_index) + 3'd1), "digest word index skipped")

  // The last flag marks word four and nothing else
  `SHA1BSH_ASSERT(a_last_on_four, out_valid_o |-> (out_data_o.last_word == (out_data_o.word_index == 3'd4)), "last flag on wrong word")

  // The digest ends after the last word is taken
  `SHA1BSH_ASSERT_ALWAYS(a_end_after_last, (rst_ni && out_valid_o && !out_stall_i && out_data_o.last_word) |=> !out_valid_o, "digest output ran on")

endmodule

bind sha1_byte_stream_hasher_core sha1bsh_checker u_sha1bsh_checker (.*);

// ----- tb/sv/sha1_digest_check_pkg.sv -----
// Scoreboard class for the SHA-1 byte stream hasher: digest predictor and result checker.
`timescale 1ns / 1ps

package sha1_digest_check_pkg;
  import sha1bsh_pkg::*;

  class sha1_digest_scoreboard;
    logic [31:0]        chain_words [SHA1_WORDS];
    logic [7:0]         block_bytes [64];
    int unsigned        fill_level;
    logic [COUNT_W-1:0] msg_bytes;
    sha1bsh_out_t       digest_queue [$];

    int unsigned mismatches;
    int unsigned words_checked;
    int unsigned words_noted;
    int unsigned messages_done;
    int unsigned blocks_done;

    function new();
      mismatches    = 0;
      words_checked = 0;
      words_noted   = 0;
      messages_done = 0;
      blocks_done   = 0;
      fill_level    = 0;
      msg_bytes     = '0;
      foreach (block_bytes[i]) block_bytes[i] = 8'h00;
      load_iv();
    endfunction

    function void load_iv();
      for (int unsigned i = 0; i < SHA1_WORDS; i++) chain_words[i] = SHA1_IV[i];
    endfunction

    function logic [31:0] rol(logic [31:0] v, int unsigned s);
      return (v << s) | (v >> (32 - s));
    endfunction

    // One 80-round compression over the buffered block, schedule in a 16-word window
    function void compress();
      logic [31:0] sched [16];
      logic [31:0] a, b, c, d, e, f, k, t, x;
      int unsigned slot;
      for (int unsigned i = 0; i < 16; i++) begin
        sched[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2],
                    block_bytes[4*i+3]};
      end
      a = chain_words[0];
      b = chain_words[1];
      c = chain_words[2];
      d = chain_words[3];
      e = chain_words[4];
      for (int unsigned r = 0; r < SHA1_ROUNDS; r++) begin
        slot = r & 15;
        if (r >= 16) begin
          x = sched[(r + 13) & 15] ^ sched[(r + 8) & 15] ^ sched[(r + 2) & 15] ^ sched[slot];
          sched[slot] = rol(x, 1);
        end
        if (r < 20) begin
          f = (b & c) | (~b & d);
          k = SHA1_K0;
        end else if (r < 40) begin
          f = b ^ c ^ d;
          k = SHA1_K1;
        end else if (r < 60) begin
          f = (b & c) | (b & d) | (c & d);
          k = SHA1_K2;
        end else begin
          f = b ^ c ^ d;
          k = SHA1_K3;
        end
        t = rol(a, 5) + f + e + k + sched[slot];
        e = d;
        d = c;
        c = rol(b, 30);
        b = a;
        a = t;
      end
      chain_words[0] += a;
      chain_words[1] += b;
      chain_words[2] += c;
      chain_words[3] += d;
      chain_words[4] += e;
      blocks_done++;
    endfunction

    function void push_byte(logic [7:0] v);
      block_bytes[fill_level] = v;
      fill_level = (fill_level + 1) & 63;
      if (fill_level == 0) compress();
    endfunction

    // Accepted input word: absorb the byte, and on a final word pad and queue the digest
    function void note_word(sha1bsh_in_t w);
      logic [63:0]  bit_len;
      sha1bsh_out_t exp_word;
      words_noted++;
      if (w.byte_present) begin
        push_byte(w.data_byte);
        msg_bytes = msg_bytes + 1'b1;
      end
      if (w.is_final) begin
        bit_len = {msg_bytes, 3'b000};
        push_byte(PAD_BYTE);
        while (fill_level != 56) push_byte(8'h00);
        for (int unsigned i = 0; i < 8; i++) push_byte(bit_len[63 - 8*i -: 8]);
        for (int unsigned i = 0; i < SHA1_WORDS; i++) begin
          exp_word.digest_word = chain_words[i];
          exp_word.word_index  = 3'(i);
          exp_word.last_word   = (i == SHA1_WORDS - 1);
          digest_queue.push_back(exp_word);
        end
        load_iv();
        fill_level = 0;
        msg_bytes  = '0;
        messages_done++;
      end
    endfunction

    // Accepted output word against the oldest expected digest word
    function void check_digest_word(sha1bsh_out_t got);
      sha1bsh_out_t exp_word;
      words_checked++;
      if (digest_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected digest word: index %0d value %08h last %0b",
                   got.word_index, got.digest_word, got.last_word);
        end
      end else begin
        exp_word = digest_queue.pop_front();
        if (got !== exp_word) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("digest mismatch: expected index %0d value %08h last %0b, got index %0d value %08h last %0b",
                     exp_word.word_index, exp_word.digest_word, exp_word.last_word,
                     got.word_index, got.digest_word, got.last_word);
          end
        end
      end
    endfunction

    function bit drained();
      return digest_queue.size() == 0;
    endfunction
  endclass

endpackage

// ----- tb/sv/testbench.sv -----
// Top-level testbench of the SHA-1 byte stream hasher core.
`timescale 1ns / 1ps

module testbench;
  import sha1bsh_pkg::*;
  import sha1_digest_check_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned SETTLE_WAIT  = 100;
  localparam int unsigned TAIL_WAIT    = 200;
  localparam int unsigned PHASE_WORDS  = 72;

  logic         clk_i;
  logic         rst_ni      = 1'b0;
  logic         in_valid_i  = 1'b0;
  logic         in_stall_o;
  sha1bsh_in_t  in_data_i   = '0;
  logic         out_valid_o;
  logic         out_stall_i = 1'b0;
  sha1bsh_out_t out_data_o;

  sha1_digest_scoreboard sb;

  int unsigned idle_pct    = 0;
  int unsigned stall_pct   = 0;
  int unsigned cycle_count = 0;
  int unsigned phase_words;
  int unsigned msg_words;

  sha1_byte_stream_hasher_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Output side: check taken words, then pick the stall for the next cycle
  always @(posedge clk_i) begin
    cycle_count++;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      sb.check_digest_word(out_data_o);
    end
    if (rst_ni === 1'b1) out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("FAIL sha1_byte_stream_hasher_core");
    $finish;
  end

  function automatic sha1bsh_in_t make_word(logic [7:0] b, logic present, logic last);
    sha1bsh_in_t w;
    w.data_byte    = b;
    w.byte_present = present;
    w.is_final     = last;
    return w;
  endfunction

  // Offer one word after a random idle gap, return at the edge that takes it
  task automatic send_word(sha1bsh_in_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_word(w);
  endtask

  // Hold the input off until every digest word is back, then let the core settle
  task automatic drain(int unsigned settle);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (!sb.drained()) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // One random message, mostly short, sometimes at a padding boundary; stray empty words mixed in
  task automatic send_message(output int unsigned used);
    int unsigned n;
    int unsigned sel;
    int unsigned strays;
    bit          last_carries;
    strays = 0;
    sel = $urandom_range(99);
    if (sel < 70) begin
      n = $urandom_range(8);
    end else if (sel < 90) begin
      n = $urandom_range(40, 9);
    end else begin
      case ($urandom_range(7))
        0: n = 55;
        1: n = 56;
        2: n = 57;
        3: n = 63;
        4: n = 64;
        5: n = 65;
        6: n = 119;
        default: n = 120;
      endcase
    end
    last_carries = (n > 0) && ($urandom_range(1) == 1);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(99) < 8) begin
        send_word(make_word(8'($urandom), 1'b0, 1'b0));
        strays++;
      end
      if (last_carries && i == n - 1) send_word(make_word(8'($urandom), 1'b1, 1'b1));
      else send_word(make_word(8'($urandom), 1'b1, 1'b0));
    end
    if (!last_carries) send_word(make_word(8'($urandom), 1'b0, 1'b1));
    used = n + strays + (last_carries ? 0 : 1);
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty message, one-byte messages, stray words, byte extremes
    send_word(make_word(8'h00, 1'b0, 1'b1));
    send_word(make_word(8'hFF, 1'b0, 1'b1));
    send_word(make_word(8'hFF, 1'b0, 1'b0));
    send_word(make_word(8'hFF, 1'b1, 1'b1));
    send_word(make_word(8'h00, 1'b1, 1'b1));
    send_word(make_word(8'h61, 1'b1, 1'b0));
    send_word(make_word(8'h62, 1'b1, 1'b0));
    send_word(make_word(8'h63, 1'b1, 1'b1));
    send_word(make_word(8'h00, 1'b1, 1'b0));
    send_word(make_word(8'hA5, 1'b0, 1'b1));
    send_word(make_word(8'hFF, 1'b1, 1'b0));
    send_word(make_word(8'h00, 1'b0, 1'b0));
    send_word(make_word(8'h00, 1'b1, 1'b0));
    send_word(make_word(8'h5A, 1'b0, 1'b0));
    send_word(make_word(8'hC3, 1'b0, 1'b1));
    drain(SETTLE_WAIT);

    // Random messages under four handshake regimes
    for (int unsigned phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 78; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 78; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      phase_words = 0;
      while (phase_words < PHASE_WORDS) begin
        send_message(msg_words);
        phase_words += msg_words;
      end
      drain(SETTLE_WAIT);
    end

    stall_pct = 0;
    repeat (TAIL_WAIT) @(posedge clk_i);

    $display("Run covered %0d input words over %0d messages, %0d blocks compressed",
             sb.words_noted, sb.messages_done, sb.blocks_done);
    $display("Checked %0d digest words under four idle/stall regimes, %0d mismatches",
             sb.words_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.drained()) begin
      $display("PASS sha1_byte_stream_hasher_core");
    end else begin
      $display("FAIL sha1_byte_stream_hasher_core");
    end
    $finish;
  end

endmodule
